// File: sv/assert_macros.svh
// assertion macros for the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/hhfe_pkg.sv
// package for the http header field extractor: word types, state and key codes,
// and the keyword trie transition table; no dependencies
package hhfe_pkg;

    // input and result words
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_header;
    } t_in_word;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               value_byte;
        logic [2:0]         field_id;
        logic               value_end;
        logic               value_drop;
        logic [1:0]         method_seen;
        logic               status_valid;
        logic signed [15:0] status_code;
        logic               header_end_seen;
    } t_out_word;

    // match states; trie prefix nodes start at ST_NODE0
    localparam logic [5:0] ST_START  = 6'd0;
    localparam logic [5:0] ST_IGNORE = 6'd1;
    localparam logic [5:0] ST_BLANK  = 6'd2;
    localparam logic [5:0] ST_END    = 6'd3;
    localparam logic [5:0] ST_NODE0  = 6'd4;
    localparam logic [5:0] ST_HTTP_H = 6'd11;
    localparam logic [5:0] ST_HTTP_T = 6'd12;
    localparam logic [5:0] ST_HOST_H = 6'd17;
    localparam logic [5:0] ST_HOST_O = 6'd18;

    // keywords
    localparam logic [2:0] KEY_GET   = 3'd0;
    localparam logic [2:0] KEY_POST  = 3'd1;
    localparam logic [2:0] KEY_HTTP  = 3'd2;
    localparam logic [2:0] KEY_HOST  = 3'd3;
    localparam logic [2:0] KEY_UA    = 3'd4;
    localparam logic [2:0] KEY_REF   = 3'd5;
    localparam logic [2:0] KEY_CTYPE = 3'd6;

    // field ids
    localparam logic [2:0] FLD_PATH  = 3'd0;
    localparam logic [2:0] FLD_PROTO = 3'd1;

    // method codes
    localparam logic [1:0] METH_NONE = 2'd0;

    // status conversion phases
    localparam logic [1:0] PH_LEAD   = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_STOP   = 2'd2;

    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [15:0] STATUS_LIMIT = 16'd32768;
    localparam logic [15:0] STATUS_MAX   = 16'd32767;

    typedef struct packed {
        logic [5:0] next;
        logic       hit;
        logic [2:0] key;
    } t_trie;

    // one trie transition from line start or a prefix node
    function automatic t_trie trie_step(input logic [5:0] s, input logic [7:0] ch);
        t_trie      r;
        logic [7:0] exp_ch;
        logic [2:0] key;
        logic       last;
        logic       known;
        r      = '{next: ST_IGNORE, hit: 1'b0, key: KEY_GET};
        exp_ch = 8'h00;
        key    = KEY_GET;
        last   = 1'b0;
        known  = 1'b1;
        if (s == ST_START) begin
            case (ch)
                "G":     r.next = 6'd4;
                "P":     r.next = 6'd7;
                "H":     r.next = ST_HTTP_H;
                "U":     r.next = 6'd21;
                "R":     r.next = 6'd31;
                "C":     r.next = 6'd38;
                default: r.next = ST_IGNORE;
            endcase
        end else if (s == ST_HTTP_H && ch == "o") begin
            // "H" is shared by HTTP/1. and Host
            r.next = ST_HOST_O;
        end else if (s == ST_HOST_H && ch == "T") begin
            r.next = ST_HTTP_T;
        end else begin
            unique case (s)
                6'd4:  begin exp_ch = "E"; key = KEY_GET; end
                6'd5:  begin exp_ch = "T"; key = KEY_GET; end
                6'd6:  begin exp_ch = " "; key = KEY_GET; last = 1'b1; end
                6'd7:  begin exp_ch = "O"; key = KEY_POST; end
                6'd8:  begin exp_ch = "S"; key = KEY_POST; end
                6'd9:  begin exp_ch = "T"; key = KEY_POST; end
                6'd10: begin exp_ch = " "; key = KEY_POST; last = 1'b1; end
                6'd11: begin exp_ch = "T"; key = KEY_HTTP; end
                6'd12: begin exp_ch = "T"; key = KEY_HTTP; end
                6'd13: begin exp_ch = "P"; key = KEY_HTTP; end
                6'd14: begin exp_ch = "/"; key = KEY_HTTP; end
                6'd15: begin exp_ch = "1"; key = KEY_HTTP; end
                6'd16: begin exp_ch = "."; key = KEY_HTTP; last = 1'b1; end
                6'd17: begin exp_ch = "o"; key = KEY_HOST; end
                6'd18: begin exp_ch = "s"; key = KEY_HOST; end
                6'd19: begin exp_ch = "t"; key = KEY_HOST; end
                6'd20: begin exp_ch = ":"; key = KEY_HOST; last = 1'b1; end
                6'd21: begin exp_ch = "s"; key = KEY_UA; end
                6'd22: begin exp_ch = "e"; key = KEY_UA; end
                6'd23: begin exp_ch = "r"; key = KEY_UA; end
                6'd24: begin exp_ch = "-"; key = KEY_UA; end
                6'd25: begin exp_ch = "A"; key = KEY_UA; end
                6'd26: begin exp_ch = "g"; key = KEY_UA; end
                6'd27: begin exp_ch = "e"; key = KEY_UA; end
                6'd28: begin exp_ch = "n"; key = KEY_UA; end
                6'd29: begin exp_ch = "t"; key = KEY_UA; end
                6'd30: begin exp_ch = ":"; key = KEY_UA; last = 1'b1; end
                6'd31: begin exp_ch = "e"; key = KEY_REF; end
                6'd32: begin exp_ch = "f"; key = KEY_REF; end
                6'd33: begin exp_ch = "e"; key = KEY_REF; end
                6'd34: begin exp_ch = "r"; key = KEY_REF; end
                6'd35: begin exp_ch = "e"; key = KEY_REF; end
                6'd36: begin exp_ch = "r"; key = KEY_REF; end
                6'd37: begin exp_ch = ":"; key = KEY_REF; last = 1'b1; end
                6'd38: begin exp_ch = "o"; key = KEY_CTYPE; end
                6'd39: begin exp_ch = "n"; key = KEY_CTYPE; end
                6'd40: begin exp_ch = "t"; key = KEY_CTYPE; end
                6'd41: begin exp_ch = "e"; key = KEY_CTYPE; end
                6'd42: begin exp_ch = "n"; key = KEY_CTYPE; end
                6'd43: begin exp_ch = "t"; key = KEY_CTYPE; end
                6'd44: begin exp_ch = "-"; key = KEY_CTYPE; end
                6'd45: begin exp_ch = "T"; key = KEY_CTYPE; end
                6'd46: begin exp_ch = "y"; key = KEY_CTYPE; end
                6'd47: begin exp_ch = "p"; key = KEY_CTYPE; end
                6'd48: begin exp_ch = "e"; key = KEY_CTYPE; end
                6'd49: begin exp_ch = ":"; key = KEY_CTYPE; last = 1'b1; end
                default: known = 1'b0;
            endcase
            if (known && ch == exp_ch) begin
                if (last) begin
                    r.next = ST_START;
                    r.hit  = 1'b1;
                    r.key  = key;
                end else begin
                    r.next = s + 6'd1;
                end
            end
        end
        return r;
    endfunction

endpackage

// File: sv/http_header_field_extractor.sv
// http header field extractor: keyword trie, value marking and status conversion
// depends on hhfe_pkg
//
// Usage
//   Input channel: one header byte per word (i_in_word), with end_of_header set on
//   the last byte of the header. A word is taken on a rising edge with i_in_valid
//   high and o_in_stall low.
//   Output channel: one result word per input word, in order, on o_out_word while
//   o_out_valid is high; it is taken on an edge with i_out_stall low.
//   Latency: the result of a byte appears on the cycle after the byte is taken.
//   Throughput: one byte per cycle while the output is not stalled; the keyword
//   transition, value flags and the status multiply-by-ten step all fit between
//   the state registers and the output register.
//   Stall: o_in_stall is high while the output register holds an untaken word and
//   i_out_stall is high; a word taken in the same cycle as the output is freed
//   passes straight through, so there are no bubbles.
//   Reset: synchronous, active low; match state returns to line start, the status
//   converter clears and the output register empties.
//   End of header: after the last byte all matching state returns to reset.
module http_header_field_extractor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hhfe_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hhfe_pkg::t_out_word o_out_word
);
    import hhfe_pkg::*;

    logic [5:0]  r_state,  n_state;
    logic [2:0]  r_kind,   n_kind;
    logic [1:0]  r_lead,   n_lead;
    logic [1:0]  r_phase,  n_phase;
    logic        r_neg,    n_neg;
    logic [15:0] r_accum,  n_accum;
    logic        r_out_valid;
    t_out_word   r_out_word, n_out_word;

    logic        accept;
    logic [7:0]  ch;
    logic        eoh;
    t_trie       tr;
    logic [2:0]  kind, kind_new;
    logic        is_method;
    logic [2:0]  end_fid, end_fid_new;
    logic        is_digit, is_ws;
    logic [19:0] mul10;
    logic [15:0] accum_sat;
    logic [15:0] status_val;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign ch  = i_in_word.data_byte;
    assign eoh = i_in_word.end_of_header;
    assign tr  = trie_step(r_state, ch);

    assign kind      = (r_kind > KEY_CTYPE) ? KEY_CTYPE : r_kind;
    assign is_method = (kind <= KEY_POST);
    assign end_fid   = is_method ? FLD_PROTO :
                       ((kind >= KEY_HOST) ? kind - 3'd1 : FLD_PROTO);

    assign is_digit = (ch >= "0") && (ch <= "9");
    assign is_ws    = (ch == CH_TAB) || (ch == CH_VT) || (ch == CH_FF) || (ch == CH_CR);

    // accum * 10 + digit, saturated at 32768
    assign mul10     = ({4'd0, r_accum} << 3) + ({4'd0, r_accum} << 1) + {16'd0, ch[3:0]};
    assign accum_sat = (mul10 > {4'd0, STATUS_LIMIT}) ? STATUS_LIMIT : mul10[15:0];

    assign status_val = r_neg ? (16'd0 - r_accum) :
                        ((r_accum > STATUS_MAX) ? STATUS_MAX : r_accum);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_lead  = r_lead;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_accum = r_accum;

        n_out_word                 = '0;
        n_out_word.out_byte        = ch;
        n_out_word.header_end_seen = eoh;

        if (ch == CH_LF) begin
            if (r_state == ST_END) begin
                n_out_word.value_drop = 1'b1;
                n_out_word.field_id   = end_fid;
            end else if (r_state == ST_BLANK && is_method) begin
                n_out_word.value_drop = 1'b1;
                n_out_word.field_id   = FLD_PATH;
            end
            n_state = ST_START;
            n_lead  = 2'd0;
            n_phase = PH_LEAD;
            n_neg   = 1'b0;
            n_accum = '0;
        end else if (r_state == ST_IGNORE) begin
            n_state = r_state;
        end else if (r_state == ST_END) begin
            if (r_lead != 2'd0 && ch == CH_SPACE) begin
                n_lead = r_lead;
            end else if (ch == CH_CR) begin
                n_out_word.value_end = 1'b1;
                n_out_word.field_id  = end_fid;
                n_state              = ST_IGNORE;
            end else begin
                n_lead                = 2'd0;
                n_out_word.value_byte = 1'b1;
                n_out_word.field_id   = end_fid;
            end
        end else if (r_state == ST_BLANK) begin
            if (r_lead >= 2'd2) begin
                // minor version byte after the response keyword
                n_lead = 2'd1;
            end else if (ch == CH_SPACE && r_lead == 2'd1) begin
                n_lead = r_lead;
            end else if (ch == CH_SPACE) begin
                if (is_method) begin
                    n_out_word.value_end = 1'b1;
                    n_out_word.field_id  = FLD_PATH;
                    n_state              = ST_END;
                    n_lead               = 2'd1;
                end else begin
                    n_out_word.status_valid = 1'b1;
                    n_out_word.status_code  = status_val;
                    n_state                 = ST_IGNORE;
                end
            end else begin
                n_lead = 2'd0;
                if (is_method) begin
                    n_out_word.value_byte = 1'b1;
                    n_out_word.field_id   = FLD_PATH;
                end else begin
                    case (r_phase)
                        PH_LEAD: begin
                            if (is_ws) begin
                                n_phase = r_phase;
                            end else if (ch == "+" || ch == "-") begin
                                n_neg   = (ch == "-");
                                n_phase = PH_DIGITS;
                            end else if (!is_digit) begin
                                n_phase = PH_STOP;
                            end else begin
                                n_phase = PH_DIGITS;
                                n_accum = accum_sat;
                            end
                        end
                        PH_DIGITS: begin
                            if (!is_digit) begin
                                n_phase = PH_STOP;
                            end else begin
                                n_accum = accum_sat;
                            end
                        end
                        default: n_phase = r_phase;
                    endcase
                end
            end
        end else begin
            n_state = tr.next;
            if (tr.hit) begin
                n_kind = tr.key;
                if (tr.key <= KEY_HTTP) begin
                    n_out_word.method_seen = tr.key[1:0] + 2'd1;
                    n_state                = ST_BLANK;
                    n_lead                 = (tr.key == KEY_HTTP) ? 2'd2 : 2'd1;
                    n_phase                = PH_LEAD;
                    n_neg                  = 1'b0;
                    n_accum                = '0;
                end else begin
                    n_state = ST_END;
                    n_lead  = 2'd1;
                end
            end
        end

        // end of header ends or drops an open value, then everything resets
        if (eoh) begin
            if (!n_out_word.value_end) begin
                if (n_state == ST_END) begin
                    n_out_word.value_end = 1'b1;
                    n_out_word.field_id  = end_fid_new;
                end else if (n_state == ST_BLANK && kind_new <= KEY_POST) begin
                    n_out_word.value_drop = 1'b1;
                    n_out_word.field_id   = FLD_PATH;
                end
            end
            n_state = ST_START;
            n_kind  = KEY_GET;
            n_lead  = 2'd0;
            n_phase = PH_LEAD;
            n_neg   = 1'b0;
            n_accum = '0;
        end
    end

    // keyword as it stands after this byte, for the end-of-header close
    assign kind_new    = (tr.hit && r_state != ST_IGNORE && r_state != ST_END &&
                          r_state != ST_BLANK && ch != CH_LF) ? tr.key : kind;
    assign end_fid_new = (kind_new <= KEY_POST) ? FLD_PROTO :
                         ((kind_new >= KEY_HOST) ? kind_new - 3'd1 : FLD_PROTO);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_START;
            r_kind      <= KEY_GET;
            r_lead      <= 2'd0;
            r_phase     <= PH_LEAD;
            r_neg       <= 1'b0;
            r_accum     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_kind      <= n_kind;
                r_lead      <= n_lead;
                r_phase     <= n_phase;
                r_neg       <= n_neg;
                r_accum     <= n_accum;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

// File: sv/hhfe_checker.sv
// port-level assertions for the http header field extractor, bound to the top level
// depends on hhfe_pkg and assert_macros.svh
`include "assert_macros.svh"

module hhfe_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input hhfe_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input hhfe_pkg::t_out_word o_out_word
);
    import hhfe_pkg::*;

    // every taken byte shows up, echoed, on the next cycle
    `ASSERT_NEXT(a_echo_next, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_out_valid && o_out_word.out_byte == $past(i_in_word.data_byte), "taken byte not echoed on the next cycle")

    // a stalled result word holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word), "stalled result word changed")

    `ASSERT_IMPL(a_status_zero, i_clk, i_rst_n, o_out_valid && !o_out_word.status_valid, o_out_word.status_code == 16'sd0, "status code set without status valid")

    `ASSERT_IMPL(a_fid_idle, i_clk, i_rst_n, o_out_valid && !o_out_word.value_byte && !o_out_word.value_end && !o_out_word.value_drop, o_out_word.field_id == FLD_PATH, "field id set with no value flag")

    `ASSERT_IMPL(a_key_no_value, i_clk, i_rst_n, o_out_valid && o_out_word.method_seen != METH_NONE, !o_out_word.value_byte && !o_out_word.status_valid, "keyword byte marked as value")

endmodule

bind http_header_field_extractor hhfe_checker u_hhfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
